FILE: rtl/core/dmx_pkg.sv
// Shared types, constants and sample arithmetic for the stereo downmixer.
package dmx_pkg;

  localparam int unsigned MaxChannels = 8;
  localparam int unsigned PosW        = $clog2(MaxChannels);
  localparam int unsigned CountW      = 4;
  localparam int unsigned FmtW        = 2;
  localparam int unsigned WordW       = 32;
  localparam int unsigned SampW       = 27;   // Q4.23
  localparam int unsigned SumW        = 28;
  localparam int unsigned OutW        = 24;   // Q1.23
  localparam int unsigned WeightW     = 16;
  localparam int unsigned ProdW       = SampW + WeightW;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 4;

  // 0.7071 in Q1.15
  localparam logic signed [WeightW-1:0] WeightK = 16'sd23170;

  typedef enum logic [FmtW-1:0] {
    FMT_PCM16 = 2'd0,
    FMT_PCM24 = 2'd1,
    FMT_PCM32 = 2'd2,
    FMT_FLT32 = 2'd3
  } fmt_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FORMAT = 1'b0,
    REG_COUNT  = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    W_NONE  = 2'd0,
    W_UNITY = 2'd1,
    W_K     = 2'd2,
    W_HALF  = 2'd3
  } weight_e;

  // Routing of one channel into the two sums, plus frame end flag.
  typedef struct packed {
    weight_e left;
    weight_e right;
    logic    last;
  } route_t;

  function automatic logic signed [SampW-1:0] decode_float(input logic [WordW-1:0] w);
    logic [7:0]       e;
    logic [23:0]      m;
    logic [7:0]       sh;
    logic [SampW-1:0] mag;
    logic signed [SampW-1:0] res;
    e   = w[30:23];
    m   = {1'b1, w[22:0]};
    sh  = 8'd127 - e;
    mag = '0;
    if (e == 8'hFF || e == 8'h00) begin
      res = '0;
    end else if (e >= 8'd130) begin
      res = w[31] ? {1'b1, {(SampW-1){1'b0}}} : {1'b0, {(SampW-1){1'b1}}};
    end else begin
      if (e >= 8'd127) begin
        mag = {3'b000, m} << (e - 8'd127);
      end else if (sh >= 8'd24) begin
        mag = '0;
      end else begin
        mag = {3'b000, m} >> sh[4:0];
      end
      res = w[31] ? -$signed(mag) : $signed(mag);
    end
    return res;
  endfunction

  function automatic logic signed [SampW-1:0] decode(input fmt_e fmt,
                                                     input logic [WordW-1:0] w);
    logic signed [SampW-1:0] res;
    unique case (fmt)
      FMT_PCM16: res = {{3{w[15]}}, w[15:0], 8'h00};
      FMT_PCM24: res = {{3{w[23]}}, w[23:0]};
      FMT_PCM32: res = {{3{w[31]}}, w[31:8]};
      FMT_FLT32: res = decode_float(w);
      default:   res = '0;
    endcase
    return res;
  endfunction

  // Add a weighted sample to a sum and clamp to the sum range.
  function automatic logic signed [SumW-1:0] acc_sat(input logic signed [SumW-1:0] s,
                                                     input logic signed [SampW-1:0] a);
    logic signed [SumW:0] t;
    logic signed [SumW-1:0] res;
    t = {s[SumW-1], s} + {{2{a[SampW-1]}}, a};
    if (t[SumW] != t[SumW-1]) begin
      res = t[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      res = t[SumW-1:0];
    end
    return res;
  endfunction

  // Clamp a sum to the Q1.23 output range.
  function automatic logic signed [OutW-1:0] out_sat(input logic signed [SumW-1:0] s);
    logic signed [OutW-1:0] res;
    if (s[SumW-1] && !(&s[SumW-2:OutW-1])) begin
      res = {1'b1, {(OutW-1){1'b0}}};
    end else if (!s[SumW-1] && (|s[SumW-2:OutW-1])) begin
      res = {1'b0, {(OutW-1){1'b1}}};
    end else begin
      res = s[OutW-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/pcm_multichannel_stereo_downmix.sv
// Multichannel PCM to stereo downmixer: decode, weight, accumulate, emit per frame.
//
//  channel   | port group        | payload (lowest bit first)
//  ----------+-------------------+-------------------------------------------
//  input     | s_axis_*          | tdata[31:0]  sample_word
//  output    | m_axis_*          | tdata[23:0]  left_out, tdata[47:24] right_out
//  config    | cfg_we/idx/data_i | idx 0 sample_format, idx 1 channel_count
//
// One item per cycle is accepted while the input is not stalled. While an item sits
// in the input register, decode, the 27x16 weight multiply and the sum update run;
// a frame result is written to the output register when the frame's last item
// leaves the input register. The input stalls only when a frame end sits in the
// input register while a result waits in the output register and the receiver
// holds off. Reset clears the sums, the channel position, both valid flags and
// the configuration (pcm16, two channels).
module pcm_multichannel_stereo_downmix (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dmx_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [dmx_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [dmx_pkg::WordW-1:0]          s_axis_tdata_i,   // sample_word
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [2*dmx_pkg::OutW-1:0]         m_axis_tdata_o    // left_out, right_out
);

  dmx_pkg::fmt_e                     fmt_q;
  logic [dmx_pkg::CountW-1:0]        count_q;
  logic [dmx_pkg::PosW-1:0]          pos_q, pos_d;
  logic [dmx_pkg::CountW-1:0]        count_eff;
  dmx_pkg::route_t                   route_d, route_q;
  logic                              in_valid_q;
  logic [dmx_pkg::WordW-1:0]         word_q;
  logic                              out_valid_q;
  logic signed [dmx_pkg::OutW-1:0]   left_out_q, right_out_q;
  logic signed [dmx_pkg::SumW-1:0]   left_sum_q, right_sum_q;
  logic signed [dmx_pkg::SumW-1:0]   left_new, right_new;
  logic signed [dmx_pkg::SampW-1:0]  x, kx, hx, left_add, right_add;
  logic signed [dmx_pkg::ProdW-1:0]  prod;
  logic                              advance;
  logic                              accept;

  // Clamp the channel count: zero acts as one, above the maximum as the maximum.
  always_comb begin
    if (count_q == '0) begin
      count_eff = dmx_pkg::CountW'(1);
    end else if (count_q > dmx_pkg::CountW'(dmx_pkg::MaxChannels)) begin
      count_eff = dmx_pkg::CountW'(dmx_pkg::MaxChannels);
    end else begin
      count_eff = count_q;
    end
  end

  // Route the incoming channel by position and channel count.
  always_comb begin
    route_d.left  = dmx_pkg::W_NONE;
    route_d.right = dmx_pkg::W_NONE;
    route_d.last  = ({1'b0, pos_q} + 4'd1) >= count_eff;
    unique case (pos_q)
      3'd0: begin
        route_d.left = dmx_pkg::W_UNITY;
        if (count_eff == 4'd1) route_d.right = dmx_pkg::W_UNITY;
      end
      3'd1: route_d.right = dmx_pkg::W_UNITY;
      3'd2: begin
        if (count_eff == 4'd3 || count_eff >= 4'd5) begin
          route_d.left  = dmx_pkg::W_K;
          route_d.right = dmx_pkg::W_K;
        end else if (count_eff == 4'd4) begin
          route_d.left = dmx_pkg::W_K;
        end
      end
      3'd3: if (count_eff == 4'd4) route_d.right = dmx_pkg::W_K;
      3'd4: begin
        route_d.left = dmx_pkg::W_K;
        if (count_eff == 4'd5) route_d.right = dmx_pkg::W_K;
      end
      3'd5: route_d.right = dmx_pkg::W_K;
      3'd6: route_d.left  = dmx_pkg::W_HALF;
      3'd7: route_d.right = dmx_pkg::W_HALF;
      default: ;
    endcase
    pos_d = route_d.last ? '0 : pos_q + 3'd1;
  end

  // Hold the item in the input register while its frame result cannot be stored.
  assign advance         = in_valid_q && (!route_q.last || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Decode, weight and accumulate.
  always_comb begin
    x    = dmx_pkg::decode(fmt_q, word_q);
    prod = x * dmx_pkg::WeightK;
    kx   = prod[dmx_pkg::ProdW-2:15];
    hx   = x >>> 1;
    unique case (route_q.left)
      dmx_pkg::W_UNITY: left_add = x;
      dmx_pkg::W_K:     left_add = kx;
      dmx_pkg::W_HALF:  left_add = hx;
      default:          left_add = '0;
    endcase
    unique case (route_q.right)
      dmx_pkg::W_UNITY: right_add = x;
      dmx_pkg::W_K:     right_add = kx;
      dmx_pkg::W_HALF:  right_add = hx;
      default:          right_add = '0;
    endcase
    left_new  = dmx_pkg::acc_sat(left_sum_q, left_add);
    right_new = dmx_pkg::acc_sat(right_sum_q, right_add);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= dmx_pkg::FMT_PCM16;
      count_q     <= dmx_pkg::CountW'(2);
      pos_q       <= '0;
      in_valid_q  <= 1'b0;
      route_q     <= '0;
      out_valid_q <= 1'b0;
      left_sum_q  <= '0;
      right_sum_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (dmx_pkg::reg_idx_e'(cfg_idx_i))
          dmx_pkg::REG_FORMAT: fmt_q   <= dmx_pkg::fmt_e'(cfg_data_i[dmx_pkg::FmtW-1:0]);
          dmx_pkg::REG_COUNT:  count_q <= cfg_data_i;
          default: ;
        endcase
      end
      // Advance the channel position as items enter.
      if (accept) begin
        pos_q   <= pos_d;
        route_q <= route_d;
      end
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      // Update the sums; clear them at frame end.
      if (advance) begin
        if (route_q.last) begin
          left_sum_q  <= '0;
          right_sum_q <= '0;
        end else begin
          left_sum_q  <= left_new;
          right_sum_q <= right_new;
        end
      end
      if (advance && route_q.last) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= s_axis_tdata_i;
    end
    if (advance && route_q.last) begin
      left_out_q  <= dmx_pkg::out_sat(left_new);
      right_out_q <= dmx_pkg::out_sat(right_new);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {right_out_q, left_out_q};

  // A frame end that leaves the input stage always lands in the output register.
  a_frame_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && route_q.last |=> m_axis_tvalid_o)
    else $error("frame result lost");

  // The sums restart from zero after each frame end.
  a_sum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && route_q.last |=> left_sum_q == '0 && right_sum_q == '0)
    else $error("sums not cleared at frame end");

  // The input stalls only behind a pending frame end and a stalled output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && route_q.last && out_valid_q && !m_axis_tready_i)
    else $error("input stalled without cause");

  // A waiting result only leaves on a handshake.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

endmodule
